### hw/rtl/tcw_pkg.sv
// Package for the text console writer: item and command types, codes,
// default geometry and the cell packing helper. No dependencies.
package tcw_pkg;

  // Default screen geometry and command queue depth
  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault    = 25;
  localparam int unsigned CmdFifoDepth   = 2;

  // Character codes
  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] BlankCode   = 8'd32;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgDefaultFg = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDefaultBg = 1'b1;
  localparam logic [3:0] FgResetValue = 4'd7;
  localparam logic [3:0] BgResetValue = 4'd0;

  // Action codes on the input channel
  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Classified operations handed to the back end
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [3:0]  fore_color;
    logic [3:0]  back_color;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [10:0] idx;
    logic        in_range;
  } cmd_t;

  // Pack a character and its two colors into one screen cell
  function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

### hw/rtl/tcw_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The payload type is set at instantiation; no other dependencies.
interface tcw_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/tcw_front.sv
// Front end of the text console writer: accepts input beats and turns
// them into commands for the queue. Uses tcw_pkg and tcw_stream_if.
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned ROWS    = RowsDefault
) (
  tcw_stream_if.sink in_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;

  // Take a beat whenever the queue has room
  assign in_i.ready = !queue_full_i;
  assign push_o     = in_i.valid && !queue_full_i;

  // Classify the action and pre-check the read index
  always_comb begin
    cmd_o.ch       = in_i.data.char_code;
    cmd_o.fg       = in_i.data.fore_color;
    cmd_o.bg       = in_i.data.back_color;
    cmd_o.idx      = in_i.data.cell_index;
    cmd_o.in_range = 32'(in_i.data.cell_index) < 32'(CellCount);
    unique case (action_e'(in_i.data.action))
      ACT_PUT:   cmd_o.op = (in_i.data.char_code == NewlineCode) ? OP_NEWLINE : OP_PUT;
      ACT_CLEAR: cmd_o.op = OP_CLEAR;
      ACT_READ:  cmd_o.op = OP_READ;
      ACT_NONE:  cmd_o.op = OP_NOP;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

### hw/rtl/tcw_cmd_fifo.sv
// Short command queue between the front and back ends of the console
// writer. Uses tcw_pkg for the default depth.
module tcw_cmd_fifo import tcw_pkg::*; #(
  parameter int unsigned DEPTH = CmdFifoDepth,
  parameter type         data_t = cmd_t
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output data_t head_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  data_t            entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entries[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/tcw_back.sv
// Back end of the console writer: cursor, screen memory, scroll and clear
// sweeps, configuration registers and the result register. Uses tcw_pkg and tcw_stream_if.
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned ROWS    = RowsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               cmd_empty_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  tcw_stream_if.source       out_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned IdxW      = $clog2(CellCount);
  localparam int unsigned CntW      = $clog2(CellCount + 1);
  localparam int unsigned ColW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RowW      = $clog2(ROWS);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [IdxW-1:0]  base_q, base_d;
  logic [IdxW-1:0]  addr_q, addr_d;
  logic [CntW-1:0]  src_q, src_d;
  logic [IdxW-1:0]  wr_addr_q, wr_addr_d;
  logic             wr_valid_q, wr_valid_d;
  logic [3:0]       dfg_q, dbg_q;
  logic             out_valid_q;
  out_item_t        out_data_q, out_data_d;
  logic             out_load;

  logic [15:0]      screen_mem [CellCount];
  logic [15:0]      rd_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  logic             last_col, at_bottom;
  logic [31:0]      col_wide, row_wide;

  assign last_col  = col_q == ColW'(COLUMNS - 1);
  assign at_bottom = row_q == RowW'(ROWS - 1);
  assign col_wide  = 32'(col_q);
  assign row_wide  = 32'(row_q);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Sequencer: next state, cursor moves and memory port control
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    col_d      = col_q;
    row_d      = row_q;
    base_d     = base_q;
    addr_d     = addr_q;
    src_d      = src_q;
    wr_addr_d  = wr_addr_q;
    wr_valid_d = 1'b0;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = addr_q;
    mem_raddr  = IdxW'(cmd_q.idx);
    mem_wdata  = make_cell(BlankCode, dfg_q, dbg_q);
    out_load   = 1'b0;
    out_data_d = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (cmd_q.op)
          OP_PUT, OP_NEWLINE: begin
            if (cmd_q.op == OP_PUT) begin
              mem_we    = 1'b1;
              mem_waddr = base_q + IdxW'(col_q);
              mem_wdata = make_cell(cmd_q.ch, cmd_q.fg, cmd_q.bg);
            end
            if (cmd_q.op == OP_PUT && !last_col) begin
              col_d = col_q + 1'b1;
            end else begin
              col_d = '0;
              if (at_bottom) begin
                // Scroll: row stays at the bottom
                src_d   = CntW'(COLUMNS);
                state_d = ST_SCROLL;
              end else begin
                row_d  = row_q + 1'b1;
                base_d = base_q + IdxW'(COLUMNS);
              end
            end
          end
          OP_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            base_d  = '0;
            addr_d  = '0;
            state_d = ST_CLEAR;
          end
          OP_READ: begin
            mem_re = cmd_q.in_range;
          end
          OP_NOP: begin
          end
          default: begin
          end
        endcase
      end
      ST_SCROLL: begin
        // Read one row below, write it back one row up in the next cycle
        mem_we    = wr_valid_q;
        mem_waddr = wr_addr_q;
        mem_wdata = rd_q;
        if (src_q != CntW'(CellCount)) begin
          mem_re     = 1'b1;
          mem_raddr  = src_q[IdxW-1:0];
          src_d      = src_q + 1'b1;
          wr_valid_d = 1'b1;
          wr_addr_d  = IdxW'(src_q - CntW'(COLUMNS));
        end else begin
          addr_d  = IdxW'((ROWS - 1) * COLUMNS);
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == IdxW'(CellCount - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = make_cell(BlankCode, dbg_q, dbg_q);
        addr_d    = addr_q + 1'b1;
        if (addr_q == IdxW'(CellCount - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_data_d.cell_data     = (cmd_q.op == OP_READ && cmd_q.in_range) ? rd_q : 16'd0;
        out_data_d.cursor_column = col_wide[6:0];
        out_data_d.cursor_row    = row_wide[4:0];
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      src_q       <= '0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      base_q     <= base_d;
      src_q      <= src_d;
      wr_valid_q <= wr_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfg_q <= FgResetValue;
      dbg_q <= BgResetValue;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDefaultFg: dfg_q <= cfg_data_i;
        CfgDefaultBg: dbg_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    wr_addr_q <= wr_addr_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= screen_mem[mem_raddr];
    end
  end

endmodule

### hw/rtl/text_console_writer.sv
// Text console writer: put, newline, read and no-op items pass through the
// pop, execute and result steps of the back-end sequencer, one item at a
// time while the command queue takes further beats. A scroll adds a sweep
// that copies each row up and blank-fills the bottom row, and a clear a
// sweep over every cell, one memory write a cycle. Reset homes the cursor
// and loads the default colors; screen memory is not cleared.
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned ROWS    = RowsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  tcw_stream_if.sink         in_i,
  tcw_stream_if.source       out_o
);

  logic push, pop, full, empty;
  cmd_t push_cmd, head_cmd;

  // Accept and classify beats
  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_i        (in_i),
    .queue_full_i(full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Queue commands between the two ends
  tcw_cmd_fifo #(
    .DEPTH (CmdFifoDepth),
    .data_t(cmd_t)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (empty)
  );

  // Carry out commands on the screen
  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_empty_i(empty),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (pop),
    .out_o      (out_o)
  );

endmodule

### hw/rtl/tcw_checker.sv
// Port-level checker for the text console writer and its bind statement.
// Uses tcw_pkg for the queue depth and default geometry.
module tcw_checker import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned ROWS    = RowsDefault
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  localparam int unsigned MaxPending = CmdFifoDepth + 2;
  localparam int unsigned PendW      = $clog2(MaxPending + 2);

  logic             in_beat, out_beat;
  logic [PendW-1:0] pending_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat dropped or changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result shown with no item outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= MaxPending)
    else $error("more items outstanding than the design can hold");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_data_i.cursor_column) < COLUMNS &&
                    32'(out_data_i.cursor_row) < ROWS)
    else $error("cursor reported outside the screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
